// ===== rtl/fsp_pkg.sv =====
package fsp_pkg;

  localparam int VALUE_BITS_DEF = 32;

  // Field widths of one item on each side
  localparam int CHAR_W  = 8;
  localparam int STAR_W  = 32;
  localparam int CNT_W   = 4;
  localparam int NFLAGS  = 5;
  localparam int FIELD_W = 32;
  localparam int MOD_W   = 3;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 96;

  // Flag slots
  localparam logic [2:0] FL_ZERO  = 3'd0;
  localparam logic [2:0] FL_MINUS = 3'd1;
  localparam logic [2:0] FL_PLUS  = 3'd2;
  localparam logic [2:0] FL_POUND = 3'd3;
  localparam logic [2:0] FL_SPACE = 3'd4;

  // Characters with a role in the grammar
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_POUND = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_J     = 8'h6a;
  localparam logic [7:0] CH_Z     = 8'h7a;

  // Length modifier codes
  localparam logic [2:0] LM_NONE = 3'd0;
  localparam logic [2:0] LM_HH   = 3'd1;
  localparam logic [2:0] LM_H    = 3'd2;
  localparam logic [2:0] LM_L    = 3'd3;
  localparam logic [2:0] LM_LL   = 3'd4;
  localparam logic [2:0] LM_J    = 3'd5;
  localparam logic [2:0] LM_Z    = 3'd6;

  typedef enum logic [7:0] {
    PH_FLAGS  = 8'b0000_0001,
    PH_WDIG   = 8'b0000_0010,
    PH_WDONE  = 8'b0000_0100,
    PH_PFIRST = 8'b0000_1000,
    PH_PSKIP  = 8'b0001_0000,
    PH_HSEEN  = 8'b0010_0000,
    PH_LSEEN  = 8'b0100_0000,
    PH_CONV   = 8'b1000_0000
  } phase_t;

  // One of s S p d D i o O u U x X c C
  function automatic logic is_conv(input logic [7:0] c);
    logic hit;
    unique case (c)
      8'h73, 8'h53, 8'h70, 8'h64, 8'h44, 8'h69, 8'h6f,
      8'h4f, 8'h75, 8'h55, 8'h78, 8'h58, 8'h63, 8'h43: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ===== rtl/format_spec_parser.sv =====
// An item's result, if any, is registered in the result register behind the input register.
// Throughput: one item per cycle while results drain; the per-character state update is a
// single pass of logic between the input register and the result register.
// A stalled result holds the parser, and the input register then holds one more item.
// Reset (rst, synchronous, active high) empties both registers and returns the parser to
// the flags phase with all counts and values cleared.
module format_spec_parser #(
  parameter int VALUE_BITS = fsp_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // char_code [7:0], star_value [39:8]
  input  logic [fsp_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // conv_char [7:0], zero_count [11:8], minus_count [15:12], plus_count [19:16],
  // pound_count [23:20], space_count [27:24], field_width [59:28], prec_present [60],
  // precision [92:61], length_mod [95:93]
  output logic [fsp_pkg::OUT_W-1:0] m_tdata,
  // spec_valid [0]
  output logic [0:0]                m_tuser
);

  // Accumulators hold at least the 32 bits of a star value
  localparam int AW = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam logic [AW-1:0] ACC_MAX = AW'((65'd1 << (VALUE_BITS - 1)) - 65'd1);

  // Append one decimal digit, saturating at the largest positive value.
  // acc*10 + d > max is the same test as acc > (max - d) / 10.
  function automatic logic [AW-1:0] acc_digit(input logic [AW-1:0] acc,
                                               input logic [3:0] d);
    logic [AW+3:0] sum;
    sum = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (AW+4)'(d);
    return (sum > {4'd0, ACC_MAX}) ? ACC_MAX : sum[AW-1:0];
  endfunction

  // Input register
  logic                       in_vld;
  logic [7:0]                 in_char;
  logic [fsp_pkg::STAR_W-1:0] in_star;
  logic                       consume;

  // Parser state
  fsp_pkg::phase_t           phase, phase_next;
  logic [fsp_pkg::CNT_W-1:0] cnt      [fsp_pkg::NFLAGS];
  logic [fsp_pkg::CNT_W-1:0] cnt_next [fsp_pkg::NFLAGS];
  logic [AW-1:0]             wacc, wacc_next;
  logic [AW-1:0]             pacc, pacc_next;
  logic                      pseen, pseen_next;
  logic                      plive, plive_next;
  logic [fsp_pkg::MOD_W-1:0] mod, mod_next;

  // Per-character decode
  logic       emit;
  logic       at_wdone;
  logic       at_mod;
  logic       flag_hit;
  logic [2:0] flag_idx;
  logic [3:0] digit;
  logic       char_digit;
  logic [AW-1:0] star_ext;
  logic [fsp_pkg::MOD_W-1:0] mod_out;

  // Result register
  logic                        out_vld;
  logic                        r_valid;
  logic [7:0]                  r_char;
  logic [fsp_pkg::CNT_W-1:0]   r_cnt [fsp_pkg::NFLAGS];
  logic [fsp_pkg::FIELD_W-1:0] r_width;
  logic                        r_pseen;
  logic [fsp_pkg::FIELD_W-1:0] r_prec;
  logic [fsp_pkg::MOD_W-1:0]   r_mod;

  // Advance the parser whenever the result slot is free or drains this cycle
  assign consume  = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata[7:0];
      in_star <= s_tdata[39:8];
    end
  end

  assign digit      = in_char[3:0];
  assign char_digit = fsp_pkg::is_digit(in_char);
  assign star_ext   = AW'($signed(in_star));

  always_comb begin
    flag_hit = 1'b1;
    flag_idx = fsp_pkg::FL_ZERO;
    unique case (in_char)
      fsp_pkg::CH_ZERO:  flag_idx = fsp_pkg::FL_ZERO;
      fsp_pkg::CH_MINUS: flag_idx = fsp_pkg::FL_MINUS;
      fsp_pkg::CH_PLUS:  flag_idx = fsp_pkg::FL_PLUS;
      fsp_pkg::CH_POUND: flag_idx = fsp_pkg::FL_POUND;
      fsp_pkg::CH_SPACE: flag_idx = fsp_pkg::FL_SPACE;
      default:           flag_hit = 1'b0;
    endcase
  end

  // One character through the grammar. A character that does not fit the current
  // position falls through to the next one within the same cycle.
  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    wacc_next  = wacc;
    pacc_next  = pacc;
    pseen_next = pseen;
    plive_next = plive;
    mod_next   = mod;
    emit       = 1'b0;
    at_wdone   = 1'b0;
    at_mod     = 1'b0;

    unique case (phase)
      fsp_pkg::PH_FLAGS: begin
        if (flag_hit) begin
          if (cnt[flag_idx] != '1) begin
            cnt_next[flag_idx] = cnt[flag_idx] + 1'b1;
          end
        end else if (in_char >= fsp_pkg::CH_ONE && in_char <= fsp_pkg::CH_NINE) begin
          wacc_next  = AW'(digit);
          phase_next = fsp_pkg::PH_WDIG;
        end else if (in_char == fsp_pkg::CH_STAR) begin
          wacc_next  = star_ext;
          phase_next = fsp_pkg::PH_WDONE;
        end else begin
          at_wdone = 1'b1;
        end
      end
      fsp_pkg::PH_WDIG: begin
        if (char_digit) begin
          wacc_next = acc_digit(wacc, digit);
        end else begin
          at_wdone = 1'b1;
        end
      end
      fsp_pkg::PH_WDONE: at_wdone = 1'b1;
      fsp_pkg::PH_PFIRST: begin
        if (in_char == fsp_pkg::CH_STAR) begin
          pacc_next  = star_ext;
          plive_next = 1'b0;
          phase_next = fsp_pkg::PH_PSKIP;
        end else if (char_digit) begin
          pacc_next  = AW'(digit);
          plive_next = 1'b1;
          phase_next = fsp_pkg::PH_PSKIP;
        end else begin
          at_mod = 1'b1;
        end
      end
      fsp_pkg::PH_PSKIP: begin
        if (char_digit) begin
          if (plive) begin
            pacc_next = acc_digit(pacc, digit);
          end
        end else if (in_char == fsp_pkg::CH_STAR) begin
          plive_next = 1'b0;
        end else begin
          at_mod = 1'b1;
        end
      end
      fsp_pkg::PH_HSEEN: begin
        if (in_char == fsp_pkg::CH_H) begin
          mod_next   = fsp_pkg::LM_HH;
          phase_next = fsp_pkg::PH_CONV;
        end else begin
          mod_next = fsp_pkg::LM_H;
          emit     = 1'b1;
        end
      end
      fsp_pkg::PH_LSEEN: begin
        if (in_char == fsp_pkg::CH_L) begin
          mod_next   = fsp_pkg::LM_LL;
          phase_next = fsp_pkg::PH_CONV;
        end else begin
          mod_next = fsp_pkg::LM_L;
          emit     = 1'b1;
        end
      end
      fsp_pkg::PH_CONV: emit = 1'b1;
      default: emit = 1'b1;
    endcase

    // Precision position, reached once the width is done
    if (at_wdone) begin
      if (in_char == fsp_pkg::CH_DOT) begin
        pseen_next = 1'b1;
        phase_next = fsp_pkg::PH_PFIRST;
      end else begin
        at_mod = 1'b1;
      end
    end

    // Length modifier position
    if (at_mod) begin
      priority if (in_char == fsp_pkg::CH_H) begin
        phase_next = fsp_pkg::PH_HSEEN;
      end else if (in_char == fsp_pkg::CH_L) begin
        phase_next = fsp_pkg::PH_LSEEN;
      end else if (in_char == fsp_pkg::CH_J) begin
        mod_next   = fsp_pkg::LM_J;
        phase_next = fsp_pkg::PH_CONV;
      end else if (in_char == fsp_pkg::CH_Z) begin
        mod_next   = fsp_pkg::LM_Z;
        phase_next = fsp_pkg::PH_CONV;
      end else begin
        emit = 1'b1;
      end
    end

    // Modifier as it stands on the terminating character, before the clear below
    mod_out = mod_next;

    // The terminating character drops all state for the next specifier
    if (emit) begin
      phase_next = fsp_pkg::PH_FLAGS;
      for (int k = 0; k < fsp_pkg::NFLAGS; k++) begin
        cnt_next[k] = '0;
      end
      wacc_next  = '0;
      pacc_next  = '0;
      pseen_next = 1'b0;
      plive_next = 1'b0;
      mod_next   = fsp_pkg::LM_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= fsp_pkg::PH_FLAGS;
      for (int k = 0; k < fsp_pkg::NFLAGS; k++) begin
        cnt[k] <= '0;
      end
      wacc  <= '0;
      pacc  <= '0;
      pseen <= 1'b0;
      plive <= 1'b0;
      mod   <= fsp_pkg::LM_NONE;
    end else if (consume) begin
      phase <= phase_next;
      cnt   <= cnt_next;
      wacc  <= wacc_next;
      pacc  <= pacc_next;
      pseen <= pseen_next;
      plive <= plive_next;
      mod   <= mod_next;
    end
  end

  // Result register: load on a terminating character, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (consume && emit) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
    if (consume && emit) begin
      r_valid <= fsp_pkg::is_conv(in_char);
      r_char  <= in_char;
      r_cnt   <= cnt;
      r_width <= wacc[fsp_pkg::FIELD_W-1:0];
      r_pseen <= pseen;
      r_prec  <= pacc[fsp_pkg::FIELD_W-1:0];
      r_mod   <= mod_out;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tuser  = r_valid;
  assign m_tdata  = {r_mod, r_prec, r_pseen, r_width,
                     r_cnt[fsp_pkg::FL_SPACE], r_cnt[fsp_pkg::FL_POUND],
                     r_cnt[fsp_pkg::FL_PLUS], r_cnt[fsp_pkg::FL_MINUS],
                     r_cnt[fsp_pkg::FL_ZERO], r_char};

endmodule
